/* hw/rtl/mrp_pkg.sv */
// ----------------------------------------------------------------------------
// mrp_pkg
// Shared widths, payload types and divider stage type for the mirror
// reflection point unit.
// ----------------------------------------------------------------------------
package mrp_pkg;

    // coordinate and intermediate widths
    localparam int CW  = 32;            // coordinate
    localparam int DW  = CW + 1;        // coordinate difference
    localparam int PW  = 2 * DW;        // difference product
    localparam int SW  = PW + 1;        // sum of two products
    localparam int EW  = SW + 1;        // e + k
    localparam int NW  = SW + EW;       // num and den
    localparam int XW  = DW + NW;       // offset numerator
    localparam int QB  = CW + 2;        // quotient bits before rounding
    localparam int AW  = QB + 3;        // sum of base and rounded offset

    localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

    // one lane of the divider chain
    typedef struct packed {
        logic [XW-1:0]          rem;
        logic [QB-1:0]          quo;
        logic                   neg;
        logic                   big;
        logic signed [CW-1:0]   base;
    } mrp_lane_t;

    // payload moving along the divider chain
    typedef struct packed {
        mrp_lane_t              lx;
        mrp_lane_t              ly;
        logic [XW-1:0]          dsh;
        logic [NW-1:0]          den;
        logic                   no_hit;
    } mrp_div_t;

endpackage

/* hw/rtl/mrp_if.sv */
// ----------------------------------------------------------------------------
// mrp_if
// Request and result channels of the mirror reflection point unit.
// ----------------------------------------------------------------------------
interface mrp_query_if;
    import mrp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [CW-1:0]   mirror_ax;
    logic signed [CW-1:0]   mirror_ay;
    logic signed [CW-1:0]   mirror_bx;
    logic signed [CW-1:0]   mirror_by;
    logic signed [CW-1:0]   source_x;
    logic signed [CW-1:0]   source_y;
    logic signed [CW-1:0]   target_x;
    logic signed [CW-1:0]   target_y;

    modport source (output valid, mirror_ax, mirror_ay, mirror_bx, mirror_by,
                    source_x, source_y, target_x, target_y, input ready);
    modport sink   (input valid, mirror_ax, mirror_ay, mirror_bx, mirror_by,
                    source_x, source_y, target_x, target_y, output ready);
endinterface

interface mrp_result_if;
    import mrp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [CW-1:0]   hit_x;
    logic signed [CW-1:0]   hit_y;
    logic                   no_hit;
    logic                   clipped;

    modport source (output valid, hit_x, hit_y, no_hit, clipped, input ready);
    modport sink   (input valid, hit_x, hit_y, no_hit, clipped, output ready);
endinterface

/* hw/rtl/mrp_front.sv */
// ----------------------------------------------------------------------------
// mrp_front
// Geometry front end: differences, cross and dot products, the offset
// numerators and the common denominator, reduced to magnitudes for the
// divider chain.
// ----------------------------------------------------------------------------
module mrp_front
    import mrp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [CW-1:0]    ax,
    input  logic signed [CW-1:0]    ay,
    input  logic signed [CW-1:0]    bx,
    input  logic signed [CW-1:0]    by,
    input  logic signed [CW-1:0]    sx,
    input  logic signed [CW-1:0]    sy,
    input  logic signed [CW-1:0]    tx,
    input  logic signed [CW-1:0]    ty,
    output logic                    out_valid,
    output mrp_div_t                out_data
);

    logic [7:0] vld_reg;

    // stage 1: differences
    logic signed [CW-1:0] ax1_reg, ay1_reg;
    logic signed [DW-1:0] dx1_reg, dy1_reg, rsx1_reg, rsy1_reg, rtx1_reg, rty1_reg;
    // stage 2: products
    logic signed [CW-1:0] ax2_reg, ay2_reg;
    logic signed [DW-1:0] dx2_reg, dy2_reg;
    logic signed [PW-1:0] pxx_reg, pyy_reg, pxsy_reg, pysx_reg, pxty_reg, pytx_reg;
    logic signed [PW-1:0] pxsx_reg, pysy_reg, pxtx_reg, pyty_reg;
    // stage 3: cross and dot products
    logic signed [CW-1:0] ax3_reg, ay3_reg;
    logic signed [DW-1:0] dx3_reg, dy3_reg;
    logic signed [SW-1:0] dd3_reg, k3_reg, e3_reg, ps3_reg, pt3_reg;
    logic signed [EW-1:0] ek3_reg;
    logic signed [SW-1:0] k_next, e_next;
    // stages 4 to 6: num and den, one multiplier limb per stage
    logic signed [CW-1:0] ax4_reg, ay4_reg, ax5_reg, ay5_reg, ax6_reg, ay6_reg;
    logic signed [DW-1:0] dx4_reg, dy4_reg, dx5_reg, dy5_reg, dx6_reg, dy6_reg;
    logic signed [SW-1:0] ps4_reg, pt4_reg, e4_reg, k4_reg, dd4_reg;
    logic signed [SW-1:0] ps5_reg, pt5_reg, e5_reg, k5_reg, dd5_reg;
    logic signed [EW-1:0] ek4_reg, ek5_reg;
    logic signed [NW-1:0] num4_reg, den4_reg, num5_reg, den5_reg, num6_reg, den6_reg;
    logic                 nh4_reg, nh5_reg, nh6_reg;
    // stage 7: offset numerators
    logic signed [CW-1:0] ax7_reg, ay7_reg;
    logic signed [XW-1:0] nx7_reg, ny7_reg;
    logic signed [NW-1:0] den7_reg;
    logic                 nh7_reg;
    // stage 8: magnitudes
    mrp_div_t             div_reg;
    logic [XW-1:0]        anx, any;
    logic [NW-1:0]        aden;

    // narrow signed product
    function automatic logic signed [PW-1:0] mul_dw(
        input logic signed [DW-1:0] a,
        input logic signed [DW-1:0] b
    );
        return PW'(a) * PW'(b);
    endfunction

    // limbs of a cross or dot product term, low two unsigned, top signed
    function automatic logic signed [DW-1:0] limb_lo(input logic signed [SW-1:0] v);
        return {1'b0, v[CW-1:0]};
    endfunction

    function automatic logic signed [DW-1:0] limb_mid(input logic signed [SW-1:0] v);
        return {1'b0, v[2*CW-1:CW]};
    endfunction

    function automatic logic signed [DW-1:0] limb_hi(input logic signed [SW-1:0] v);
        return DW'($signed(v[SW-1:2*CW]));
    endfunction

    // whole multiplicand times one limb, as three narrow products
    function automatic logic signed [EW+DW-1:0] mul_row(
        input logic signed [EW-1:0] a,
        input logic signed [DW-1:0] b
    );
        logic signed [DW-1:0] a0, a1, a2;
        a0 = {1'b0, a[CW-1:0]};
        a1 = {1'b0, a[2*CW-1:CW]};
        a2 = DW'($signed(a[EW-1:2*CW]));
        return ((EW+DW)'(mul_dw(a2, b)) <<< (2*CW)) + ((EW+DW)'(mul_dw(a1, b)) <<< CW)
             + (EW+DW)'(mul_dw(a0, b));
    endfunction

    // direction component times num, as five narrow products
    function automatic logic signed [XW-1:0] mul_num(
        input logic signed [DW-1:0] d,
        input logic signed [NW-1:0] n
    );
        logic signed [DW-1:0] n0, n1, n2, n3, n4;
        n0 = {1'b0, n[CW-1:0]};
        n1 = {1'b0, n[2*CW-1:CW]};
        n2 = {1'b0, n[3*CW-1:2*CW]};
        n3 = {1'b0, n[4*CW-1:3*CW]};
        n4 = DW'($signed(n[NW-1:4*CW]));
        return XW'(mul_dw(d, n0)) + (XW'(mul_dw(d, n1)) <<< CW)
             + (XW'(mul_dw(d, n2)) <<< (2*CW)) + (XW'(mul_dw(d, n3)) <<< (3*CW))
             + (XW'(mul_dw(d, n4)) <<< (4*CW));
    endfunction

    // valid shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[6:0], in_valid};
        end
    end

    // cross and dot products from the stage 2 terms
    always_comb
    begin
        k_next = SW'(pxsy_reg) - SW'(pysx_reg);
        e_next = SW'(pxty_reg) - SW'(pytx_reg);
    end

    // magnitudes for the divider
    always_comb
    begin
        anx  = nx7_reg[XW-1] ? XW'(-nx7_reg) : XW'(nx7_reg);
        any  = ny7_reg[XW-1] ? XW'(-ny7_reg) : XW'(ny7_reg);
        aden = den7_reg[NW-1] ? NW'(-den7_reg) : NW'(den7_reg);
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax1_reg  <= ax;
            ay1_reg  <= ay;
            dx1_reg  <= DW'(bx) - DW'(ax);
            dy1_reg  <= DW'(by) - DW'(ay);
            rsx1_reg <= DW'(sx) - DW'(ax);
            rsy1_reg <= DW'(sy) - DW'(ay);
            rtx1_reg <= DW'(tx) - DW'(ax);
            rty1_reg <= DW'(ty) - DW'(ay);

            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
            dx2_reg  <= dx1_reg;
            dy2_reg  <= dy1_reg;
            pxx_reg  <= PW'(dx1_reg) * PW'(dx1_reg);
            pyy_reg  <= PW'(dy1_reg) * PW'(dy1_reg);
            pxsy_reg <= PW'(dx1_reg) * PW'(rsy1_reg);
            pysx_reg <= PW'(dy1_reg) * PW'(rsx1_reg);
            pxty_reg <= PW'(dx1_reg) * PW'(rty1_reg);
            pytx_reg <= PW'(dy1_reg) * PW'(rtx1_reg);
            pxsx_reg <= PW'(dx1_reg) * PW'(rsx1_reg);
            pysy_reg <= PW'(dy1_reg) * PW'(rsy1_reg);
            pxtx_reg <= PW'(dx1_reg) * PW'(rtx1_reg);
            pyty_reg <= PW'(dy1_reg) * PW'(rty1_reg);

            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
            dx3_reg  <= dx2_reg;
            dy3_reg  <= dy2_reg;
            dd3_reg  <= SW'(pxx_reg) + SW'(pyy_reg);
            k3_reg   <= k_next;
            e3_reg   <= e_next;
            ps3_reg  <= SW'(pxsx_reg) + SW'(pysy_reg);
            pt3_reg  <= SW'(pxtx_reg) + SW'(pyty_reg);
            ek3_reg  <= EW'(k_next) + EW'(e_next);

            // low limb of the multipliers
            ax4_reg  <= ax3_reg;
            ay4_reg  <= ay3_reg;
            dx4_reg  <= dx3_reg;
            dy4_reg  <= dy3_reg;
            ps4_reg  <= ps3_reg;
            pt4_reg  <= pt3_reg;
            e4_reg   <= e3_reg;
            k4_reg   <= k3_reg;
            dd4_reg  <= dd3_reg;
            ek4_reg  <= ek3_reg;
            num4_reg <= NW'(mul_row(EW'(ps3_reg), limb_lo(e3_reg)))
                      + NW'(mul_row(EW'(pt3_reg), limb_lo(k3_reg)));
            den4_reg <= NW'(mul_row(ek3_reg, limb_lo(dd3_reg)));
            nh4_reg  <= (dd3_reg == '0) || (ek3_reg == '0);

            // middle limb
            ax5_reg  <= ax4_reg;
            ay5_reg  <= ay4_reg;
            dx5_reg  <= dx4_reg;
            dy5_reg  <= dy4_reg;
            ps5_reg  <= ps4_reg;
            pt5_reg  <= pt4_reg;
            e5_reg   <= e4_reg;
            k5_reg   <= k4_reg;
            dd5_reg  <= dd4_reg;
            ek5_reg  <= ek4_reg;
            num5_reg <= num4_reg
                      + (NW'(mul_row(EW'(ps4_reg), limb_mid(e4_reg))) <<< CW)
                      + (NW'(mul_row(EW'(pt4_reg), limb_mid(k4_reg))) <<< CW);
            den5_reg <= den4_reg + (NW'(mul_row(ek4_reg, limb_mid(dd4_reg))) <<< CW);
            nh5_reg  <= nh4_reg;

            // top limb
            ax6_reg  <= ax5_reg;
            ay6_reg  <= ay5_reg;
            dx6_reg  <= dx5_reg;
            dy6_reg  <= dy5_reg;
            num6_reg <= num5_reg
                      + (NW'(mul_row(EW'(ps5_reg), limb_hi(e5_reg))) <<< (2*CW))
                      + (NW'(mul_row(EW'(pt5_reg), limb_hi(k5_reg))) <<< (2*CW));
            den6_reg <= den5_reg + (NW'(mul_row(ek5_reg, limb_hi(dd5_reg))) <<< (2*CW));
            nh6_reg  <= nh5_reg;

            ax7_reg  <= ax6_reg;
            ay7_reg  <= ay6_reg;
            nx7_reg  <= mul_num(dx6_reg, num6_reg);
            ny7_reg  <= mul_num(dy6_reg, num6_reg);
            den7_reg <= den6_reg;
            nh7_reg  <= nh6_reg;

            div_reg.lx.rem  <= anx;
            div_reg.lx.quo  <= '0;
            div_reg.lx.neg  <= nx7_reg[XW-1] ^ den7_reg[NW-1];
            div_reg.lx.big  <= {1'b0, anx} >= {aden, {QB{1'b0}}};
            div_reg.lx.base <= ax7_reg;
            div_reg.ly.rem  <= any;
            div_reg.ly.quo  <= '0;
            div_reg.ly.neg  <= ny7_reg[XW-1] ^ den7_reg[NW-1];
            div_reg.ly.big  <= {1'b0, any} >= {aden, {QB{1'b0}}};
            div_reg.ly.base <= ay7_reg;
            div_reg.dsh     <= {aden, {(QB-1){1'b0}}};
            div_reg.den     <= aden;
            div_reg.no_hit  <= nh7_reg;
        end
    end

    assign out_valid = vld_reg[7];
    assign out_data  = div_reg;

endmodule

/* hw/rtl/mrp_div_cell.sv */
// ----------------------------------------------------------------------------
// mrp_div_cell
// One restoring division step for both lanes: trial subtract of the shifted
// divisor, one quotient bit, divisor moved one place down.
// ----------------------------------------------------------------------------
module mrp_div_cell
    import mrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  mrp_div_t    in_data,
    output logic        out_valid,
    output mrp_div_t    out_data
);

    logic       valid_reg;
    mrp_div_t   data_reg;
    mrp_div_t   data_next;
    logic       ge_x, ge_y;

    // trial subtraction on both lanes
    always_comb
    begin
        data_next = in_data;
        ge_x = in_data.lx.rem >= in_data.dsh;
        ge_y = in_data.ly.rem >= in_data.dsh;
        if (ge_x)
        begin
            data_next.lx.rem = in_data.lx.rem - in_data.dsh;
        end
        if (ge_y)
        begin
            data_next.ly.rem = in_data.ly.rem - in_data.dsh;
        end
        data_next.lx.quo = {in_data.lx.quo[QB-2:0], ge_x};
        data_next.ly.quo = {in_data.ly.quo[QB-2:0], ge_y};
        data_next.dsh    = in_data.dsh >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* hw/rtl/mrp_back.sv */
// ----------------------------------------------------------------------------
// mrp_back
// Rounding, sign, offset from the first mirror point and saturation, into
// the result register.
// ----------------------------------------------------------------------------
module mrp_back
    import mrp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  mrp_div_t                in_data,
    output logic                    out_valid,
    output logic signed [CW-1:0]    hit_x,
    output logic signed [CW-1:0]    hit_y,
    output logic                    no_hit,
    output logic                    clipped
);

    logic                   valid_reg;
    logic signed [CW-1:0]   hx_reg, hy_reg, hx_next, hy_next;
    logic                   nh_reg, clip_reg, clip_next;
    logic                   cx, cy;

    function automatic logic signed [CW-1:0] lane_result(
        input mrp_lane_t    ln,
        input logic [NW-1:0] den,
        output logic        clip
    );
        logic               up;
        logic [QB:0]        qm;
        logic signed [AW-1:0] qs, sum;
        begin
            up   = {ln.rem[NW-1:0], 1'b0} >= {1'b0, den};
            qm   = {1'b0, ln.quo} + (QB+1)'(up);
            qs   = ln.neg ? -AW'(qm) : AW'(qm);
            sum  = AW'(ln.base) + qs;
            clip = 1'b0;
            lane_result = sum[CW-1:0];
            if (ln.big)
            begin
                clip = 1'b1;
                lane_result = ln.neg ? COORD_MIN : COORD_MAX;
            end
            else if (sum > AW'(COORD_MAX) || sum < AW'(COORD_MIN))
            begin
                clip = 1'b1;
                lane_result = sum[AW-1] ? COORD_MIN : COORD_MAX;
            end
        end
    endfunction

    // final result, zero when there is no bounce point
    always_comb
    begin
        hx_next = lane_result(in_data.lx, in_data.den, cx);
        hy_next = lane_result(in_data.ly, in_data.den, cy);
        clip_next = cx | cy;
        if (in_data.no_hit)
        begin
            hx_next   = '0;
            hy_next   = '0;
            clip_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hx_reg   <= hx_next;
            hy_reg   <= hy_next;
            nh_reg   <= in_data.no_hit;
            clip_reg <= clip_next;
        end
    end

    assign out_valid = valid_reg;
    assign hit_x     = hx_reg;
    assign hit_y     = hy_reg;
    assign no_hit    = nh_reg;
    assign clipped   = clip_reg;

endmodule

/* hw/rtl/mirror_reflection_point_unit.sv */
// Bounce point of a ray on a flat mirror: one request per clock while the
// result is not stalled, one result per request, in order. A request passes
// eight front-end stages, a chain of 34 division cells that each settle one
// quotient bit for both coordinates, and the result register; the chain
// length follows from the quotient range needed before saturation. The
// whole pipeline advances whenever the result register is empty or being
// taken, so a stalled result holds every stage.
// ----------------------------------------------------------------------------
// mirror_reflection_point_unit
// Reflects the source across the mirror line and intersects the line from
// the reflected source to the target with the mirror, in Q16.16.
// ----------------------------------------------------------------------------
module mirror_reflection_point_unit
    import mrp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    mrp_query_if.sink       query,
    mrp_result_if.source    result
);

    logic       en;
    logic       vld [QB+1];
    mrp_div_t   dat [QB+1];

    // pipeline advance
    assign en          = !result.valid || result.ready;
    assign query.ready = en;

    mrp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (query.valid),
        .ax        (query.mirror_ax),
        .ay        (query.mirror_ay),
        .bx        (query.mirror_bx),
        .by        (query.mirror_by),
        .sx        (query.source_x),
        .sy        (query.source_y),
        .tx        (query.target_x),
        .ty        (query.target_y),
        .out_valid (vld[0]),
        .out_data  (dat[0])
    );

    // division chain
    for (genvar i = 0; i < QB; i++)
    begin : g_cell
        mrp_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (vld[i]),
            .in_data   (dat[i]),
            .out_valid (vld[i+1]),
            .out_data  (dat[i+1])
        );
    end

    mrp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld[QB]),
        .in_data   (dat[QB]),
        .out_valid (result.valid),
        .hit_x     (result.hit_x),
        .hit_y     (result.hit_y),
        .no_hit    (result.no_hit),
        .clipped   (result.clipped)
    );

endmodule

/* hw/rtl/mrp_checker.sv */
// ----------------------------------------------------------------------------
// mrp_checker
// Port-level checks on the mirror reflection point unit.
// ----------------------------------------------------------------------------
module mrp_checker
    import mrp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_ready,
    input  logic                    r_valid,
    input  logic                    r_ready,
    input  logic signed [CW-1:0]    hit_x,
    input  logic signed [CW-1:0]    hit_y,
    input  logic                    no_hit,
    input  logic                    clipped
);

    // no bounce point gives zero coordinates and no clipping
    a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && no_hit |-> hit_x == '0 && hit_y == '0 && !clipped)
        else $error("no_hit result with nonzero fields");

    // clipping leaves a coordinate on a bound
    a_clip_bound: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && clipped |-> hit_x == COORD_MAX || hit_x == COORD_MIN ||
                               hit_y == COORD_MAX || hit_y == COORD_MIN)
        else $error("clipped result off the bounds");

    // empty result register never blocks a request
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !r_valid |-> q_ready)
        else $error("request refused with empty output");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> r_valid && $stable(hit_x) && $stable(hit_y)
                                && $stable(no_hit) && $stable(clipped))
        else $error("stalled result changed");

endmodule

bind mirror_reflection_point_unit mrp_checker u_mrp_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_ready (query.ready),
    .r_valid (result.valid),
    .r_ready (result.ready),
    .hit_x   (result.hit_x),
    .hit_y   (result.hit_y),
    .no_hit  (result.no_hit),
    .clipped (result.clipped)
);

/* verif/mirror_reflection_point_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mirror_reflection_point_unit_tb
// Sends bounce point requests through the query channel and checks every
// result, in order, against a wide integer computation of the reflection
// and line intersection, with random idling on both channels.
// ----------------------------------------------------------------------------
module mirror_reflection_point_unit_tb;
    import mrp_pkg::*;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic signed [CW-1:0] ax, ay, bx, by, sx, sy, tx, ty;
    } mirror_query_t;

    typedef struct {
        logic signed [CW-1:0] hit_x, hit_y;
        logic                 no_hit, clipped;
    } bounce_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mrp_query_if  query ();
    mrp_result_if result ();

    mirror_reflection_point_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query.sink),
        .result (result.source)
    );

    mirror_query_t pending_queries[$];
    bounce_t       expected_bounces[$];
    int            fail_count = 0;
    int            query_total = 0;
    int            queries_sent = 0;
    int            send_idle_pct = 8;
    int            recv_stall_pct = 80;
    logic          query_taken = 1'b0;

    always #5 clk = ~clk;

    // rounded quotient, ties away from zero
    function automatic wide_t div_round(wide_t n, wide_t d);
        logic [255:0] un, ud, q, r;
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        q = un / ud;
        r = un % ud;
        if ((r << 1) >= ud)
            q = q + 1;
        return ((n < 0) != (d < 0)) ? -wide_t'(q) : wide_t'(q);
    endfunction

    function automatic logic signed [CW-1:0] saturate(wide_t h, ref logic clip);
        if (h > wide_t'(COORD_MAX))
        begin
            clip = 1'b1;
            return COORD_MAX;
        end
        if (h < wide_t'(COORD_MIN))
        begin
            clip = 1'b1;
            return COORD_MIN;
        end
        return h[CW-1:0];
    endfunction

    // bounce point: reflect source across mirror, intersect with target line
    function automatic bounce_t bounce_point(mirror_query_t q);
        wide_t ax, ay, dx, dy, rsx, rsy, rtx, rty;
        wide_t len2, k, e, ps, pt, ek, num, den;
        logic clip;
        bounce_t b;
        ax = q.ax;
        ay = q.ay;
        dx = wide_t'(q.bx) - ax;
        dy = wide_t'(q.by) - ay;
        rsx = wide_t'(q.sx) - ax;
        rsy = wide_t'(q.sy) - ay;
        rtx = wide_t'(q.tx) - ax;
        rty = wide_t'(q.ty) - ay;
        len2 = dx * dx + dy * dy;
        k = dx * rsy - dy * rsx;
        e = dx * rty - dy * rtx;
        ps = dx * rsx + dy * rsy;
        pt = dx * rtx + dy * rty;
        ek = e + k;
        b = '{0, 0, 1'b0, 1'b0};
        if (len2 == 0 || ek == 0)
        begin
            b.no_hit = 1'b1;
            return b;
        end
        num = ps * e + pt * k;
        den = ek * len2;
        clip = 1'b0;
        b.hit_x = saturate(ax + div_round(dx * num, den), clip);
        b.hit_y = saturate(ay + div_round(dy * num, den), clip);
        b.clipped = clip;
        return b;
    endfunction

    function automatic logic signed [CW-1:0] rnd_coord(int span);
        if (span >= 31)
            return $urandom;
        return $signed($urandom_range((1 << (span + 1)) - 1)) - (1 << span);
    endfunction

    task automatic push_query(logic signed [CW-1:0] ax, ay, bx, by, sx, sy, tx, ty);
        mirror_query_t q;
        q = '{ax, ay, bx, by, sx, sy, tx, ty};
        pending_queries.insert(pending_queries.size(), q);
    endtask

    // request driver, changes on the falling edge
    initial
    begin
        query.valid = 1'b0;
        {query.mirror_ax, query.mirror_ay, query.mirror_bx, query.mirror_by} = '0;
        {query.source_x, query.source_y, query.target_x, query.target_y} = '0;
        result.ready = 1'b0;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (queries_sent < query_total / 3)
            begin
                send_idle_pct <= 8;
                recv_stall_pct <= 80;
            end
            else if (queries_sent < 2 * query_total / 3)
            begin
                send_idle_pct <= 80;
                recv_stall_pct <= 8;
            end
            else
            begin
                send_idle_pct <= 0;
                recv_stall_pct <= 0;
            end
            result.ready <= ($urandom_range(99) >= recv_stall_pct);
            if (!query.valid || query_taken)
            begin
                if (pending_queries.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    query.mirror_ax <= pending_queries[0].ax;
                    query.mirror_ay <= pending_queries[0].ay;
                    query.mirror_bx <= pending_queries[0].bx;
                    query.mirror_by <= pending_queries[0].by;
                    query.source_x  <= pending_queries[0].sx;
                    query.source_y  <= pending_queries[0].sy;
                    query.target_x  <= pending_queries[0].tx;
                    query.target_y  <= pending_queries[0].ty;
                    query.valid     <= 1'b1;
                    void'(pending_queries.pop_front());
                    queries_sent <= queries_sent + 1;
                end
                else
                begin
                    query.valid <= 1'b0;
                end
            end
        end
    end

    // monitor, samples on the rising edge
    always @(posedge clk)
    begin
        mirror_query_t q;
        bounce_t exp_b;
        query_taken <= query.valid && query.ready;
        if (rst_n && query.valid && query.ready)
        begin
            q = '{query.mirror_ax, query.mirror_ay, query.mirror_bx, query.mirror_by,
                  query.source_x, query.source_y, query.target_x, query.target_y};
            expected_bounces.insert(expected_bounces.size(), bounce_point(q));
        end
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_bounces.size() == 0)
            begin
                $error("unexpected result hit_x=%0d hit_y=%0d", result.hit_x, result.hit_y);
                fail_count++;
            end
            else
            begin
                exp_b = expected_bounces.pop_front();
                if (result.hit_x !== exp_b.hit_x)
                begin
                    $error("hit_x expected %0d got %0d", exp_b.hit_x, result.hit_x);
                    fail_count++;
                end
                if (result.hit_y !== exp_b.hit_y)
                begin
                    $error("hit_y expected %0d got %0d", exp_b.hit_y, result.hit_y);
                    fail_count++;
                end
                if (result.no_hit !== exp_b.no_hit)
                begin
                    $error("no_hit expected %0b got %0b", exp_b.no_hit, result.no_hit);
                    fail_count++;
                end
                if (result.clipped !== exp_b.clipped)
                begin
                    $error("clipped expected %0b got %0b", exp_b.clipped, result.clipped);
                    fail_count++;
                end
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        logic signed [CW-1:0] ax, ay, bx, by, sx, sy, tx, ty;
        int span;
        int kind;
        // directed: extremes, degenerate mirror, parallel, vertical and horizontal
        push_query(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                   COORD_MIN, COORD_MIN);
        push_query(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                   COORD_MAX, COORD_MAX);
        push_query(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX,
                   COORD_MAX, COORD_MIN);
        push_query(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN,
                   COORD_MAX, COORD_MAX);
        push_query(0, 0, 32'h0001_0000, 0, 32'h0001_0000, 32'h0001_0000,
                   32'h0003_0000, 32'h0001_0000);
        push_query(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 32'h0002_0000, 32'h0005_0000);
        push_query(100, 200, 100, 200, 5, 6, 7, 8);
        push_query(0, 0, 32'h0001_0000, 0, 32'h0001_0000, 32'h0002_0000,
                   32'h0003_0000, 32'hfffe_0000);
        push_query(0, 0, 32'h0001_0000, 0, 32'h0001_0000, 0, 32'h0005_0000, 0);
        push_query(0, 0, 1, 1, 1, 0, 0, 1);
        push_query(0, 0, 3, 0, 0, 1, 1, 2);
        push_query(COORD_MAX, 0, COORD_MAX, 1, 0, 0, COORD_MAX - 1, 32'h4000_0000);
        push_query(COORD_MAX - 1, 0, COORD_MAX, 1, 0, 5, 1, 3);
        push_query(0, 0, 1, 0, 0, 1, 1, -1);
        push_query(-5, -7, 9, -7, -3, 2, 11, 4);
        push_query(COORD_MIN, 0, COORD_MIN, 1, COORD_MAX, 0, COORD_MAX, 1000);
        push_query(32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555,
                   32'h1234_5678, 32'h8765_4321, 32'hdead_beef, 32'h0bad_cafe);
        // random: mostly small geometry, some full range and special cases
        repeat (800)
        begin
            kind = $urandom_range(99);
            span = (kind < 25) ? 31 : $urandom_range(30, 4);
            ax = rnd_coord(span);
            ay = rnd_coord(span);
            bx = rnd_coord(span);
            by = rnd_coord(span);
            sx = rnd_coord(span);
            sy = rnd_coord(span);
            tx = rnd_coord(span);
            ty = rnd_coord(span);
            if (kind >= 88 && kind < 93)
            begin
                bx = ax;
                by = ay;
            end
            else if (kind >= 93 && span < 30)
            begin
                // target mirrored through A gives e = -k
                tx = 2 * ax - sx;
                ty = 2 * ay - sy;
            end
            push_query(ax, ay, bx, by, sx, sy, tx, ty);
        end
        query_total = pending_queries.size();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (pending_queries.size() == 0);
        @(posedge clk);
        while (query.valid)
            @(posedge clk);
        while (expected_bounces.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // overall time limit
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

/* mirror_reflection_point_unit.f */
hw/rtl/mrp_pkg.sv
hw/rtl/mrp_if.sv
hw/rtl/mrp_front.sv
hw/rtl/mrp_div_cell.sv
hw/rtl/mrp_back.sv
hw/rtl/mirror_reflection_point_unit.sv
hw/rtl/mrp_checker.sv
verif/mirror_reflection_point_unit_tb.sv
